@@ src/cfsu_pkg.sv @@
package cfsu_pkg;

  localparam int unsigned NumMsgs  = 18;
  localparam int unsigned IdW      = 11;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned SigW     = 4;
  localparam int unsigned ValueW   = 32;

  localparam logic [IdW-1:0] IdBaseReset = 11'd160;

  // Identifier offset from the base for each message slot
  localparam logic [7:0] MsgOffset [NumMsgs] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
    8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h22
  };

  // Slots with a layout of their own; all others carry four 16-bit fields
  localparam logic [SlotW-1:0] SlotAnalog = 5'd3;
  localparam logic [SlotW-1:0] SlotBytes  = 5'd4;
  localparam logic [SlotW-1:0] SlotStatus = 5'd10;
  localparam logic [SlotW-1:0] SlotMixed  = 5'd12;
  localparam logic [SlotW-1:0] SlotDiag   = 5'd15;
  localparam logic [SlotW-1:0] SlotShort  = 5'd17;

  typedef struct packed {
    logic [SlotW-1:0]    slot;
    logic [PayloadW-1:0] payload;
  } frame_t;

  function automatic logic [SigW-1:0] sig_count(input logic [SlotW-1:0] slot);
    logic [SigW-1:0] n;
    unique case (slot)
      SlotAnalog: n = 4'd6;
      SlotBytes:  n = 4'd8;
      SlotStatus: n = 4'd11;
      SlotMixed:  n = 4'd3;
      SlotDiag:   n = 4'd2;
      SlotShort:  n = 4'd3;
      default:    n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pbyte(input logic [PayloadW-1:0] p, input logic [2:0] k);
    return p[8*k +: 8];
  endfunction

  function automatic logic [ValueW-1:0] sig_value(input logic [SlotW-1:0]    slot,
                                                  input logic [SigW-1:0]     sig,
                                                  input logic [PayloadW-1:0] p);
    logic [ValueW-1:0] v;
    v = '0;
    unique case (slot)
      SlotAnalog: begin
        unique case (sig)
          4'd0:    v = {22'd0, p[9:0]};
          4'd1:    v = {22'd0, p[19:10]};
          4'd2:    v = {22'd0, p[29:20]};
          4'd3:    v = {22'd0, p[41:32]};
          4'd4:    v = {22'd0, p[51:42]};
          default: v = {22'd0, p[61:52]};
        endcase
      end
      SlotBytes: v = {24'd0, pbyte(p, sig[2:0])};
      SlotStatus: begin
        unique case (sig)
          4'd0:    v = {16'd0, p[15:0]};
          4'd1:    v = {24'd0, p[23:16]};
          4'd2:    v = {24'd0, p[31:24]};
          4'd3:    v = {31'd0, p[32]};
          4'd4:    v = {29'd0, p[39:37]};
          4'd5:    v = {24'd0, p[47:40]};
          4'd6:    v = {31'd0, p[48]};
          4'd7:    v = {31'd0, p[55]};
          4'd8:    v = {31'd0, p[56]};
          4'd9:    v = {31'd0, p[57]};
          default: v = {31'd0, p[58]};
        endcase
      end
      SlotMixed: begin
        unique case (sig)
          4'd0:    v = {16'd0, p[15:0]};
          4'd1:    v = {16'd0, p[31:16]};
          default: v = p[63:32];
        endcase
      end
      SlotDiag: begin
        if (sig == 4'd0) begin
          v = {p[7:0], p[15:8], p[23:16], p[31:24]};
        end else begin
          v = {p[39:32], p[47:40], p[55:48], p[63:56]};
        end
      end
      SlotShort: begin
        unique case (sig)
          4'd0:    v = {16'd0, p[15:0]};
          4'd1:    v = {24'd0, p[23:16]};
          default: v = {16'd0, p[47:32]};
        endcase
      end
      default: v = {16'd0, p[16*sig[1:0] +: 16]};
    endcase
    return v;
  endfunction

endpackage

@@ src/cfsu_ram.sv @@
module cfsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/can_frame_signal_unpacker.sv @@
// CAN receive-frame signal unpacker.
// Input channel (in_valid_i/in_ready_o) carries one frame: can_id_i and the
// eight data bytes in payload_i. The identifier is matched against the 18
// known messages (cfg base plus fixed offset) on transfer; frames with an
// unknown identifier are dropped, matched frames go into a small frame
// buffer RAM of FRAME_DEPTH entries.
// Output channel (out_valid_o/out_ready_i) carries one decoded signal per
// transfer, tagged with message_slot_o and signal_slot_o; last_o marks the
// final signal of a frame.
// Path: the frame buffer write, the buffer read, the registered RAM read data,
// then one signal per cycle into the output register while the receiver
// accepts. Each frame pays the buffer read and the RAM read data step before
// its first signal; the buffer read port sets the gap between frames.
// in_ready_o stays high while the frame buffer has room, so frames keep
// arriving while a result waits. A stalled receiver holds the output
// register and the buffered frames; nothing is lost.
// cfg_we_i writes the base identifier; write it only while idle.
// Reset empties the buffer and the output and sets the base to 160.
module can_frame_signal_unpacker #(
  parameter int unsigned FRAME_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfsu_pkg::IdW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cfsu_pkg::IdW-1:0]      can_id_i,
  input  logic [cfsu_pkg::PayloadW-1:0] payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cfsu_pkg::SlotW-1:0]    message_slot_o,
  output logic [cfsu_pkg::SigW-1:0]     signal_slot_o,
  output logic [cfsu_pkg::ValueW-1:0]   value_o,
  output logic                          last_o
);

  localparam int unsigned PtrW   = $clog2(FRAME_DEPTH);
  localparam int unsigned CntW   = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned FrameW = $bits(cfsu_pkg::frame_t);

  logic [cfsu_pkg::IdW-1:0] id_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_base_q <= cfsu_pkg::IdBaseReset;
    end else if (cfg_we_i) begin
      id_base_q <= cfg_wdata_i;
    end
  end

  // Identifier match; the sum is one bit wider so a large base never wraps
  logic                       hit;
  logic [cfsu_pkg::SlotW-1:0] hit_slot;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int m = 0; m < cfsu_pkg::NumMsgs; m++) begin
      if (({1'b0, id_base_q} + {4'd0, cfsu_pkg::MsgOffset[m]}) == {1'b0, can_id_i}) begin
        hit      = 1'b1;
        hit_slot = cfsu_pkg::SlotW'(m);
      end
    end
  end

  // Frame buffer
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            in_xfer, wr_en, rd_en;
  cfsu_pkg::frame_t wr_frame, cur_frame;

  assign in_ready_o = (count_q != CntW'(FRAME_DEPTH));
  assign in_xfer    = in_valid_i && in_ready_o;
  assign wr_en      = in_xfer && hit;

  assign wr_frame.slot    = hit_slot;
  assign wr_frame.payload = payload_i;

  logic [FrameW-1:0] rdata;

  cfsu_ram #(
    .Width (FrameW),
    .Depth (FRAME_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_ptr_q),
    .wdata_i (wr_frame),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign cur_frame = cfsu_pkg::frame_t'(rdata);

  // Emitter: the registered read data holds the current frame until the next read
  logic                      cur_valid_q, rd_pending_q;
  logic [cfsu_pkg::SigW-1:0] sig_q;
  logic                      emit, emit_last;

  assign rd_en     = !cur_valid_q && !rd_pending_q && (count_q != '0);
  assign emit      = cur_valid_q && (!out_valid_o || out_ready_i);
  assign emit_last = (sig_q == cfsu_pkg::sig_count(cur_frame.slot) - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
      rd_pending_q <= 1'b0;
      cur_valid_q  <= 1'b0;
      sig_q        <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FRAME_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FRAME_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (!wr_en && rd_en) begin
        count_q <= count_q - 1'b1;
      end
      rd_pending_q <= rd_en;
      if (rd_pending_q) begin
        cur_valid_q <= 1'b1;
        sig_q       <= '0;
      end else if (emit) begin
        if (emit_last) begin
          cur_valid_q <= 1'b0;
        end else begin
          sig_q <= sig_q + 1'b1;
        end
      end
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [cfsu_pkg::SlotW-1:0]  slot_q;
  logic [cfsu_pkg::SigW-1:0]   sig_out_q;
  logic [cfsu_pkg::ValueW-1:0] value_q;
  logic                        last_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      slot_q    <= cur_frame.slot;
      sig_out_q <= sig_q;
      value_q   <= cfsu_pkg::sig_value(cur_frame.slot, sig_q, cur_frame.payload);
      last_q    <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign message_slot_o = slot_q;
  assign signal_slot_o  = sig_out_q;
  assign value_o        = value_q;
  assign last_o         = last_q;

endmodule
